@@ design/btkrs_pkg.sv @@
// Shared types and constants of the bounded top-K recent selector.
`default_nettype none

package btkrs_pkg;

   localparam int DATE_W      = 63;
   localparam int ID_W        = 63;
   localparam int LIMIT_W     = 6;
   localparam int LIMIT_EXT_W = LIMIT_W + 1;
   localparam int CSR_DATA_W  = 64;
   localparam int CSR_ADDR_W  = 4;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET    = 6'd20;
   localparam logic [DATE_W-1:0]  MAX_DATE_RESET = {DATE_W{1'b1}};

   localparam logic OP_OFFER   = 1'b0;
   localparam logic OP_READOUT = 1'b1;

   localparam logic REG_RESULT_LIMIT = 1'b0;
   localparam logic REG_MAX_DATE     = 1'b1;

   typedef struct packed {
      logic              opcode;
      logic [DATE_W-1:0] cand_date;
      logic [ID_W-1:0]   cand_id;
      logic              new_list;
   } req_type;

   typedef struct packed {
      logic [DATE_W-1:0] out_date;
      logic [ID_W-1:0]   out_id;
      logic              is_empty;
      logic              last;
   } rsp_type;

   typedef struct packed {
      logic [DATE_W-1:0] date;
      logic [ID_W-1:0]   id;
   } entry_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SCAN_RD,
      ST_SCAN_CMP,
      ST_DECIDE,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_INSERT,
      ST_RD_ADDR,
      ST_RD_DATA,
      ST_RD_EMPTY
   } state_type;

endpackage

`default_nettype wire

@@ design/bounded_top_k_recent_selector.sv @@
// Top level of the bounded top-K recent selector: sorted table, sequencer and register port.
`default_nettype none

// Channel   Direction  Payload                    Beat moves on
// req       in         btkrs_pkg::req_type        req_valid & req_ready
// rsp       out        btkrs_pkg::rsp_type        rsp_valid & rsp_ready
// csr       in/out     APB, 64-bit data, 4-bit    psel & penable & pwrite & pready
//
// An offer is accepted and checked against the date cutoff; then entries are scanned, a
// decision is made, entries are moved down and the candidate is written. The scan stops
// where the moves begin. A readout reads each beat from the table, then hands it over; no
// new request is taken before it ends. The single table read port and one comparator set these steps.
// Reset is synchronous and active high; it empties the table and clears the skip flag.
// A stall on the result side holds the sequencer only while it has a beat to hand over.

module bounded_top_k_recent_selector #(
   parameter int MAX_K = 32
) (
   input  wire                                   clock,
   input  wire                                   reset,

   input  wire                                   req_valid,
   output logic                                  req_ready,
   input  btkrs_pkg::req_type                    req_data,

   output logic                                  rsp_valid,
   input  wire                                   rsp_ready,
   output btkrs_pkg::rsp_type                    rsp_data,

   input  wire                                   csr_psel,
   input  wire                                   csr_penable,
   input  wire                                   csr_pwrite,
   input  wire  [btkrs_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  wire  [btkrs_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [btkrs_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                  csr_pready
);

   // Count width holds 0..MAX_K; the address width indexes the table.
   localparam int CW = $clog2(MAX_K + 1);
   localparam int AW = (MAX_K > 1) ? $clog2(MAX_K) : 1;

   // ------------------------------------------------------------------
   // Configuration registers.
   // ------------------------------------------------------------------
   logic [btkrs_pkg::LIMIT_W-1:0] result_limit_ff;
   logic [btkrs_pkg::DATE_W-1:0]  max_date_ff;
   logic                          csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         result_limit_ff <= btkrs_pkg::LIMIT_RESET;
         max_date_ff     <= btkrs_pkg::MAX_DATE_RESET;
      end else if (csr_write) begin
         // The register index is the 8-byte slot; the low address bits select nothing.
         if (csr_paddr[3] == btkrs_pkg::REG_RESULT_LIMIT) begin
            result_limit_ff <= csr_pwdata[btkrs_pkg::LIMIT_W-1:0];
         end else begin
            max_date_ff <= csr_pwdata[btkrs_pkg::DATE_W-1:0];
         end
      end
   end

   always_comb begin
      if (csr_paddr[3] == btkrs_pkg::REG_MAX_DATE) begin
         csr_prdata = btkrs_pkg::CSR_DATA_W'(max_date_ff);
      end else begin
         csr_prdata = btkrs_pkg::CSR_DATA_W'(result_limit_ff);
      end
   end

   // The limit in force: zero acts as one, and anything above the table depth as the depth.
   logic [btkrs_pkg::LIMIT_EXT_W-1:0] limit_ext;
   logic [btkrs_pkg::LIMIT_EXT_W-1:0] limit_clamped;
   logic [CW-1:0]                     lim;

   always_comb begin
      limit_ext = {1'b0, result_limit_ff};
      if (limit_ext == '0) begin
         limit_clamped = btkrs_pkg::LIMIT_EXT_W'(1);
      end else if (limit_ext > btkrs_pkg::LIMIT_EXT_W'(MAX_K)) begin
         limit_clamped = btkrs_pkg::LIMIT_EXT_W'(MAX_K);
      end else begin
         limit_clamped = limit_ext;
      end
   end

   assign lim = limit_clamped[CW-1:0];

   // ------------------------------------------------------------------
   // Entry table: one write and one registered read per cycle. Entries at and beyond
   // the fill count are never read, so the table needs no clearing.
   // ------------------------------------------------------------------
   btkrs_pkg::entry_type entry_mem [MAX_K];
   btkrs_pkg::entry_type rd_data_ff;
   logic                 mem_rd_en;
   logic [AW-1:0]        mem_rd_addr;
   logic                 mem_wr_en;
   logic [AW-1:0]        mem_wr_addr;
   btkrs_pkg::entry_type mem_wr_data;

   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         entry_mem[mem_wr_addr] <= mem_wr_data;
      end
      if (mem_rd_en) begin
         rd_data_ff <= entry_mem[mem_rd_addr];
      end
   end

   // ------------------------------------------------------------------
   // Sequencer state and the held candidate.
   // ------------------------------------------------------------------
   btkrs_pkg::state_type           state_ff,     state_in;
   logic [CW-1:0]                  count_ff,     count_in;
   logic                           skip_ff,      skip_in;
   logic [CW-1:0]                  idx_ff,       idx_in;
   logic [CW-1:0]                  pos_ff,       pos_in;
   logic [btkrs_pkg::DATE_W-1:0]   cand_date_ff, cand_date_in;
   logic [btkrs_pkg::ID_W-1:0]     cand_id_ff,   cand_id_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   btkrs_pkg::rsp_type             rsp_data_ff,  rsp_data_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= btkrs_pkg::ST_IDLE;
         count_ff     <= '0;
         skip_ff      <= 1'b0;
         idx_ff       <= '0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         skip_ff      <= skip_in;
         idx_ff       <= idx_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cand_date_ff <= cand_date_in;
      cand_id_ff   <= cand_id_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign req_ready = (state_ff == btkrs_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ------------------------------------------------------------------
   // Shared comparator. The held candidate is always one side; the other side is the
   // date cutoff while checking, and the entry just read from the table otherwise.
   // ------------------------------------------------------------------
   logic [btkrs_pkg::DATE_W-1:0] cmp_b_date;
   logic [btkrs_pkg::ID_W-1:0]   cmp_b_id;
   logic                         date_gt;
   logic                         date_eq;
   logic                         id_lt;
   logic                         id_eq;

   assign date_gt = (cand_date_ff > cmp_b_date);
   assign date_eq = (cand_date_ff == cmp_b_date);
   assign id_lt   = (cand_id_ff < cmp_b_id);
   assign id_eq   = (cand_id_ff == cmp_b_id);

   // Number of beats a readout emits, and whether the result register can take a beat.
   logic [CW-1:0] read_n;
   logic          out_free;
   logic [CW-1:0] idx_inc;
   logic [CW-1:0] idx_dec;

   assign read_n   = (count_ff < lim) ? count_ff : lim;
   assign out_free = ~rsp_valid_ff | rsp_ready;
   assign idx_inc  = idx_ff + CW'(1);
   assign idx_dec  = idx_ff - CW'(1);

   always_comb begin
      logic [CW-1:0] grown;

      grown        = count_ff;
      state_in     = state_ff;
      count_in     = count_ff;
      skip_in      = skip_ff;
      idx_in       = idx_ff;
      pos_in       = pos_ff;
      cand_date_in = cand_date_ff;
      cand_id_in   = cand_id_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_data_in  = rsp_data_ff;
      mem_rd_en    = 1'b0;
      mem_rd_addr  = idx_ff[AW-1:0];
      mem_wr_en    = 1'b0;
      mem_wr_addr  = idx_ff[AW-1:0];
      mem_wr_data  = rd_data_ff;
      cmp_b_date   = rd_data_ff.date;
      cmp_b_id     = rd_data_ff.id;

      unique case (state_ff)
         btkrs_pkg::ST_IDLE: begin
            if (req_valid) begin
               idx_in = '0;
               if (req_data.opcode == btkrs_pkg::OP_READOUT) begin
                  if (read_n == '0) begin
                     state_in = btkrs_pkg::ST_RD_EMPTY;
                  end else begin
                     state_in = btkrs_pkg::ST_RD_ADDR;
                  end
               end else begin
                  cand_date_in = req_data.cand_date;
                  cand_id_in   = req_data.cand_id;
                  // A new list clears the skip flag before the offer is judged.
                  if (req_data.new_list) begin
                     skip_in = 1'b0;
                  end
                  if (!skip_ff || req_data.new_list) begin
                     state_in = btkrs_pkg::ST_CHECK;
                  end
               end
            end
         end

         btkrs_pkg::ST_CHECK: begin
            cmp_b_date = max_date_ff;
            if (date_gt || date_eq) begin
               state_in = btkrs_pkg::ST_IDLE;
            end else begin
               state_in = btkrs_pkg::ST_SCAN_RD;
            end
         end

         btkrs_pkg::ST_SCAN_RD: begin
            if (idx_ff == count_ff) begin
               pos_in   = count_ff;
               state_in = btkrs_pkg::ST_DECIDE;
            end else begin
               mem_rd_en = 1'b1;
               state_in  = btkrs_pkg::ST_SCAN_CMP;
            end
         end

         btkrs_pkg::ST_SCAN_CMP: begin
            // The table is strictly ordered, so an equal entry shows up before any
            // entry that the candidate outranks.
            if (date_eq && id_eq) begin
               state_in = btkrs_pkg::ST_IDLE;
            end else if (date_gt || (date_eq && id_lt)) begin
               pos_in   = idx_ff;
               state_in = btkrs_pkg::ST_DECIDE;
            end else begin
               idx_in   = idx_inc;
               state_in = btkrs_pkg::ST_SCAN_RD;
            end
         end

         btkrs_pkg::ST_DECIDE: begin
            if (count_ff >= lim && pos_ff >= count_ff) begin
               skip_in  = 1'b1;
               state_in = btkrs_pkg::ST_IDLE;
            end else begin
               if (count_ff < CW'(MAX_K)) begin
                  idx_in = count_ff;
                  grown  = count_ff + CW'(1);
               end else begin
                  // A full table drops its last entry off the end.
                  idx_in = CW'(MAX_K - 1);
                  grown  = count_ff;
               end
               count_in = (grown > lim) ? lim : grown;
               state_in = btkrs_pkg::ST_SHIFT_RD;
            end
         end

         btkrs_pkg::ST_SHIFT_RD: begin
            if (idx_ff > pos_ff) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = idx_dec[AW-1:0];
               state_in    = btkrs_pkg::ST_SHIFT_WR;
            end else begin
               state_in = btkrs_pkg::ST_INSERT;
            end
         end

         btkrs_pkg::ST_SHIFT_WR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = idx_ff[AW-1:0];
            mem_wr_data = rd_data_ff;
            idx_in      = idx_dec;
            state_in    = btkrs_pkg::ST_SHIFT_RD;
         end

         btkrs_pkg::ST_INSERT: begin
            mem_wr_en        = 1'b1;
            mem_wr_addr      = pos_ff[AW-1:0];
            mem_wr_data.date = cand_date_ff;
            mem_wr_data.id   = cand_id_ff;
            state_in         = btkrs_pkg::ST_IDLE;
         end

         btkrs_pkg::ST_RD_ADDR: begin
            mem_rd_en = 1'b1;
            state_in  = btkrs_pkg::ST_RD_DATA;
         end

         btkrs_pkg::ST_RD_DATA: begin
            if (out_free) begin
               rsp_valid_in         = 1'b1;
               rsp_data_in.out_date = rd_data_ff.date;
               rsp_data_in.out_id   = rd_data_ff.id;
               rsp_data_in.is_empty = 1'b0;
               rsp_data_in.last     = (idx_inc == read_n);
               idx_in               = idx_inc;
               if (idx_inc == read_n) begin
                  count_in = '0;
                  skip_in  = 1'b0;
                  state_in = btkrs_pkg::ST_IDLE;
               end else begin
                  state_in = btkrs_pkg::ST_RD_ADDR;
               end
            end
         end

         btkrs_pkg::ST_RD_EMPTY: begin
            if (out_free) begin
               rsp_valid_in         = 1'b1;
               rsp_data_in.out_date = '0;
               rsp_data_in.out_id   = '0;
               rsp_data_in.is_empty = 1'b1;
               rsp_data_in.last     = 1'b1;
               count_in             = '0;
               skip_in              = 1'b0;
               state_in             = btkrs_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = btkrs_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

@@ design/btkrs_checker.sv @@
// Port-level checks of the bounded top-K recent selector, bound to its top level.
`default_nettype none

module btkrs_checker (
   input wire                clock,
   input wire                reset,
   input wire                rsp_valid,
   input wire                rsp_ready,
   input btkrs_pkg::rsp_type rsp_data,
   input wire                csr_pready
);

   // A result beat that is not taken stays offered and unchanged.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result beat dropped or changed while stalled");

   // The empty marker only ever closes a readout on its own.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.is_empty |-> rsp_data.last)
      else $error("empty result without last mark");

   // An empty result carries no entry.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.is_empty |-> rsp_data.out_date == '0 && rsp_data.out_id == '0)
      else $error("empty result with nonzero payload");

   // Reset leaves no result pending and the register port ready.
   assert property (@(posedge clock)
      reset |=> !rsp_valid && csr_pready)
      else $error("result pending or register port stalled after reset");

endmodule

bind bounded_top_k_recent_selector btkrs_checker u_btkrs_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_valid),
   .rsp_ready  (rsp_ready),
   .rsp_data   (rsp_data),
   .csr_pready (csr_pready)
);

`default_nettype wire
